FILE: hdl/bdpd_pkg.sv
// shared types and constants for the button debounce and press detect block
package bdpd_pkg;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_LOW    = 2'd0,
    CFG_DEBOUNCE_MS   = 2'd1,
    CFG_LONG_PRESS_MS = 2'd2
  } cfg_idx_t;

  // reset values of the configuration registers
  localparam logic                  ACTIVE_LOW_RST    = 1'b1;
  localparam logic [CFG_DATA_W-1:0] DEBOUNCE_MS_RST   = 16'd50;
  localparam logic [CFG_DATA_W-1:0] LONG_PRESS_MS_RST = 16'd1000;

  typedef struct packed {
    logic       pin_level;
    logic [7:0] elapsed_ms;
    logic       clear_short;
    logic       clear_long;
  } in_word_t;

  typedef struct packed {
    logic pressed;
    logic short_press;
    logic long_press;
  } out_word_t;

  typedef struct packed {
    logic                  active_low;
    logic [CFG_DATA_W-1:0] debounce_ms;
    logic [CFG_DATA_W-1:0] long_press_ms;
  } cfg_t;

endpackage

FILE: hdl/bdpd_tracker.sv
// debounce and press tracking state with its single-pass update
module bdpd_tracker import bdpd_pkg::*; #(
  parameter int TIME_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  in_word_t  word,
  input  cfg_t      cfg,
  output out_word_t result
);

  localparam int CMP_W = (TIME_BITS > CFG_DATA_W) ? TIME_BITS : CFG_DATA_W;

  logic                 raw_prev, raw_prev_next;
  logic                 stable_level, stable_level_next;
  logic [TIME_BITS-1:0] since_change, since_change_next;
  logic [TIME_BITS-1:0] since_press, since_press_next;
  logic                 long_armed, long_armed_next;
  logic                 short_flag, short_flag_next;
  logic                 long_flag, long_flag_next;

  logic                 reading;
  logic [TIME_BITS:0]   sc_sum, sp_sum;
  logic [TIME_BITS-1:0] sc_add, sp_add;
  logic [CMP_W-1:0]     deb_x, lp_x, sp_x, sc_x;

  always_comb begin
    reading = cfg.active_low ? word.pin_level : ~word.pin_level;

    // saturating adds of the sample interval
    sc_sum = {1'b0, since_change} + (TIME_BITS+1)'(word.elapsed_ms);
    sp_sum = {1'b0, since_press} + (TIME_BITS+1)'(word.elapsed_ms);
    sc_add = sc_sum[TIME_BITS] ? '1 : sc_sum[TIME_BITS-1:0];
    sp_add = sp_sum[TIME_BITS] ? '1 : sp_sum[TIME_BITS-1:0];

    deb_x = CMP_W'(cfg.debounce_ms);
    lp_x  = CMP_W'(cfg.long_press_ms);

    short_flag_next   = short_flag & ~word.clear_short;
    long_flag_next    = long_flag & ~word.clear_long;
    since_change_next = sc_add;
    since_press_next  = sp_add;
    long_armed_next   = long_armed;
    raw_prev_next     = raw_prev;

    sp_x = CMP_W'(sp_add);
    if (reading != raw_prev) begin
      since_change_next = '0;
      if (!reading && raw_prev) begin
        // press edge
        long_armed_next  = 1'b1;
        since_press_next = '0;
      end else if (sp_x > deb_x && sp_x < lp_x) begin
        short_flag_next = 1'b1;
      end
      raw_prev_next = reading;
    end

    // long press check sees the stable level from before this update
    sp_x = CMP_W'(since_press_next);
    if (!stable_level && sp_x >= lp_x && long_armed_next) begin
      long_flag_next  = 1'b1;
      long_armed_next = 1'b0;
    end

    sc_x = CMP_W'(since_change_next);
    stable_level_next = (sc_x > deb_x) ? reading : stable_level;

    result.pressed     = ~stable_level_next;
    result.short_press = short_flag_next;
    result.long_press  = long_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_prev     <= 1'b0;
      stable_level <= 1'b1;
      since_change <= '0;
      since_press  <= '0;
      long_armed   <= 1'b0;
      short_flag   <= 1'b0;
      long_flag    <= 1'b0;
    end else if (en) begin
      raw_prev     <= raw_prev_next;
      stable_level <= stable_level_next;
      since_change <= since_change_next;
      since_press  <= since_press_next;
      long_armed   <= long_armed_next;
      short_flag   <= short_flag_next;
      long_flag    <= long_flag_next;
    end
  end

  a_long_needs_stable_press: assert property (@(posedge clk) disable iff (rst)
    $rose(long_flag) |-> !$past(stable_level))
    else $error("long press flag set without a stable press");

  a_long_disarms: assert property (@(posedge clk) disable iff (rst)
    $rose(long_flag) |-> !long_armed)
    else $error("long press left armed after firing");

  a_flags_move_on_update: assert property (@(posedge clk) disable iff (rst)
    ($rose(short_flag) || $rose(long_flag)) |-> $past(en))
    else $error("press flag changed without an update");

endmodule

FILE: hdl/button_debounce_press_detect_core.sv
// top level of the button debounce and press detect block
//
// usage
//   in channel: one word per raw pin sample (pin level, ms since the last
//   sample, clear bits for the short and long press flags); accepted at a
//   clock edge with in_valid high and in_stall low
//   out channel: exactly one word per input word (debounced pressed level,
//   short press flag, long press flag), in order; taken at a clock edge
//   with out_valid high and out_stall low
//   cfg port: cfg_we writes cfg_data into the register picked by
//   cfg_index (active_low, debounce_ms, long_press_ms); write only while
//   no word is in flight; unused indexes are ignored
// timing
//   a word passes the input register, then one pass of compares and
//   saturating adds into the result register
//   throughput is one word per cycle while out_stall is low; with a result
//   stalled, the input register takes one word if empty, then holds it
// reset
//   rst (synchronous) empties both registers, loads the register defaults
//   (active low, 50 ms, 1000 ms) and puts the tracker at released level
// stall
//   a stalled result holds; in_stall rises only when both registers are full
module button_debounce_press_detect_core import bdpd_pkg::*; #(
  parameter int TIME_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  cfg_t      cfg;

  // input register
  logic      in_q_valid;
  in_word_t  in_q;

  // pipeline control
  logic      advance;   // result register can load this cycle
  logic      update;    // an input word is processed this cycle
  out_word_t result;

  assign advance  = !out_valid || !out_stall;
  assign update   = advance && in_q_valid;
  // input register frees up when its word moves on
  assign in_stall = in_q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_low    <= ACTIVE_LOW_RST;
      cfg.debounce_ms   <= DEBOUNCE_MS_RST;
      cfg.long_press_ms <= LONG_PRESS_MS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ACTIVE_LOW:    cfg.active_low    <= cfg_data[0];
        CFG_DEBOUNCE_MS:   cfg.debounce_ms   <= cfg_data;
        CFG_LONG_PRESS_MS: cfg.long_press_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register: loads whenever it is empty or its word moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_q <= in_data;
    end
  end

  bdpd_tracker #(
    .TIME_BITS(TIME_BITS)
  ) u_tracker (
    .clk    (clk),
    .rst    (rst),
    .en     (update),
    .word   (in_q),
    .cfg    (cfg),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (update) begin
      out_data <= result;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk)
    in_stall |-> (in_q_valid && out_valid && out_stall))
    else $error("input stalled with room in the pipeline");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> (!out_valid && !in_q_valid))
    else $error("pipeline not empty after reset");

  a_update_makes_result: assert property (@(posedge clk) disable iff (rst)
    update |=> out_valid)
    else $error("processed word produced no result");

  a_held_word_kept: assert property (@(posedge clk) disable iff (rst)
    (in_q_valid && !advance) |=> in_q_valid)
    else $error("waiting input word dropped");

endmodule
